// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the modrm/sib encoder rtl
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");
`else
`define ASSERT_IMP(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/mse_pkg.sv =====
// shared types and constants for the 64-bit mov modrm/sib encoder
// no dependencies
`timescale 1ns / 1ps
package mse_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_BYTES   = 8;

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_STORE = 1'b1;

    localparam logic [7:0] REX_W         = 8'h48;
    localparam logic [7:0] OPC_LOAD      = 8'h8b;
    localparam logic [7:0] OPC_STORE     = 8'h89;
    localparam logic [1:0] MOD_NO_DISP   = 2'b00;
    localparam logic [1:0] MOD_DISP8     = 2'b01;
    localparam logic [1:0] MOD_DISP32    = 2'b10;
    localparam logic [1:0] MOD_REG       = 2'b11;
    localparam logic [2:0] RM_SIB        = 3'b100;
    localparam logic [2:0] RM_BP         = 3'b101;
    localparam logic [2:0] SIB_NO_BASE   = 3'b101;
    localparam logic [7:0] SIB_BASE_ONLY = 8'h24;
    localparam logic [3:0] REG_RSP       = 4'd4;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] code;
        logic [2:0]                last_idx;
        logic                      invalid;
    } mse_desc_t;

endpackage

// ===== rtl/core/mse_front.sv =====
// front end: accepts mov requests and turns each into a byte descriptor
// depends on mse_pkg
`timescale 1ns / 1ps
module mse_front (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,   // reg_operand, rm_register, scale_code, displacement
    input  logic [1:0]         s_tuser,   // operation, is_memory
    input  logic               full_i,
    output logic               push_o,
    output mse_pkg::mse_desc_t desc_o
);

    logic        op;
    logic [3:0]  reg_op;
    logic [3:0]  rm;
    logic        mem;
    logic [1:0]  scl;
    logic [31:0] disp;
    logic        small_disp;
    logic        zero_disp;
    logic [7:0]  rex;
    logic [1:0]  mod_f;
    logic [2:0]  rm_f;
    logic [7:0]  sib;
    logic        has_sib;
    logic [2:0]  ndisp;
    logic        bad;
    logic [39:0] tail;
    logic [3:0]  last_w;

    assign op     = s_tuser[0];
    assign mem    = s_tuser[1];
    assign reg_op = s_tdata[3:0];
    assign rm     = s_tdata[7:4];
    assign scl    = s_tdata[9:8];
    assign disp   = s_tdata[41:10];

    assign small_disp = (disp[31:7] == '0) || (disp[31:7] == '1);
    assign zero_disp  = (disp == '0);

    always_comb begin
        rex     = mse_pkg::REX_W | {5'b0, reg_op[3], 2'b00};
        mod_f   = mse_pkg::MOD_NO_DISP;
        rm_f    = rm[2:0];
        sib     = '0;
        has_sib = 1'b0;
        ndisp   = 3'd0;
        bad     = 1'b0;
        if (!mem) begin
            rex   = rex | {7'b0, rm[3]};
            mod_f = mse_pkg::MOD_REG;
        end else if (scl != 2'd0) begin
            if (rm == mse_pkg::REG_RSP) begin
                bad = 1'b1;
            end
            rex     = rex | {6'b0, rm[3], 1'b0};
            rm_f    = mse_pkg::RM_SIB;
            sib     = {scl, rm[2:0], mse_pkg::SIB_NO_BASE};
            has_sib = 1'b1;
            ndisp   = 3'd4;
        end else begin
            rex = rex | {7'b0, rm[3]};
            if (rm[2:0] == mse_pkg::RM_SIB) begin
                sib     = mse_pkg::SIB_BASE_ONLY;
                has_sib = 1'b1;
            end
            if (zero_disp && rm[2:0] != mse_pkg::RM_BP) begin
                mod_f = mse_pkg::MOD_NO_DISP;
                ndisp = 3'd0;
            end else if (small_disp) begin
                mod_f = mse_pkg::MOD_DISP8;
                ndisp = 3'd1;
            end else begin
                mod_f = mse_pkg::MOD_DISP32;
                ndisp = 3'd4;
            end
        end
    end

    assign tail   = has_sib ? {disp, sib} : {8'h00, disp};
    assign last_w = 4'd2 + {3'b0, has_sib} + {1'b0, ndisp};

    always_comb begin
        if (bad) begin
            desc_o.code     = '0;
            desc_o.last_idx = 3'd0;
            desc_o.invalid  = 1'b1;
        end else begin
            desc_o.code     = {tail, mod_f, reg_op[2:0], rm_f,
                               (op == mse_pkg::OP_STORE) ? mse_pkg::OPC_STORE
                                                         : mse_pkg::OPC_LOAD,
                               rex};
            desc_o.last_idx = last_w[2:0];
            desc_o.invalid  = 1'b0;
        end
    end

    assign s_tready = !full_i;
    assign push_o   = s_tvalid && !full_i;

endmodule

// ===== rtl/core/mse_queue.sv =====
// small descriptor queue between front and back ends
// depends on mse_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mse_queue #(
    parameter int DEPTH = mse_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_i,
    input  mse_pkg::mse_desc_t desc_i,
    input  logic               pop_i,
    output mse_pkg::mse_desc_t desc_o,
    output logic               full_o,
    output logic               empty_o
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mse_pkg::mse_desc_t data_mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full_o  = (count_reg == CW'(DEPTH));
    assign empty_o = (count_reg == '0);
    assign desc_o  = data_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_i) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_i) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_i && !pop_i) begin
            count_next = count_reg + 1'b1;
        end else if (pop_i && !push_i) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            data_mem[wr_ptr_reg] <= desc_i;
        end
    end

    `ASSERT_IMP(a_no_pop_empty, aclk, aresetn, pop_i, count_reg != '0)
    `ASSERT_IMP(a_no_push_full, aclk, aresetn, push_i, count_reg != CW'(DEPTH))
    `ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH))

endmodule

// ===== rtl/core/mse_back.sv =====
// back end: walks a descriptor and sends one code byte per cycle while m_tready does not stall
// depends on mse_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mse_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  mse_pkg::mse_desc_t desc_i,
    input  logic               empty_i,
    output logic               pop_o,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // code_byte
    output logic               m_tlast,
    output logic [0:0]         m_tuser    // invalid
);

    mse_pkg::mse_desc_t cur_reg, cur_next;
    logic [2:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       inv_reg;
    logic       out_ready;
    logic       adv;
    logic       at_last;

    assign out_ready = !out_valid_reg || m_tready;
    assign adv       = busy_reg && out_ready;
    assign at_last   = (idx_reg == cur_reg.last_idx);
    assign pop_o     = !empty_i && (!busy_reg || (adv && at_last));

    always_comb begin
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (adv) begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 1'b1;
            if (at_last) begin
                busy_next = 1'b0;
            end
        end
        if (pop_o) begin
            cur_next  = desc_i;
            idx_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (adv) begin
            byte_reg <= cur_reg.code[idx_reg];
            last_reg <= at_last;
            inv_reg  <= cur_reg.invalid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = inv_reg;

    `ASSERT_IMP(a_invalid_is_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)
    `ASSERT_IMP(a_idx_in_range, aclk, aresetn, busy_reg, idx_reg <= cur_reg.last_idx)
    `ASSERT_NEXT(a_busy_mid_item, aclk, aresetn, adv && !at_last, busy_reg && out_valid_reg)

endmodule

// ===== rtl/core/x86_64_modrm_sib_encoder.sv =====
// 64-bit mov encoder: rex, opcode, modrm, optional sib and displacement bytes
// flow: an accepted item passes through the queue, the back end's descriptor register and its output register
// throughput: one byte per cycle while m_tready does not stall; an item is 3 to 8 bytes (1 if invalid),
// set by the single byte-wide output register of the back end
// reset: synchronous active-low aresetn empties the queue and the output stage
`timescale 1ns / 1ps
module x86_64_modrm_sib_encoder #(
    parameter int QUEUE_DEPTH = mse_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // reg_operand, rm_register, scale_code, displacement
    input  logic [1:0]  s_tuser,   // operation, is_memory
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // code_byte
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // invalid
);

    mse_pkg::mse_desc_t front_desc;
    mse_pkg::mse_desc_t queue_desc;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;

    mse_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .full_i   (full),
        .push_o   (push),
        .desc_o   (front_desc)
    );

    mse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .desc_i  (front_desc),
        .pop_i   (pop),
        .desc_o  (queue_desc),
        .full_o  (full),
        .empty_o (empty)
    );

    mse_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .desc_i   (queue_desc),
        .empty_i  (empty),
        .pop_o    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== bench/mov_encoding_checker.sv =====
// checker for the 64-bit mov modrm/sib encoder: watches both stream channels,
// predicts the byte sequence of each accepted item and compares every output byte
// depends on mse_pkg for opcode, mod and sib constants
`timescale 1ns / 1ps
module mov_encoding_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // reg_operand, rm_register, scale_code, displacement
    input  logic [1:0]  s_tuser,   // operation, is_memory
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // code_byte
    input  logic        m_tlast,
    input  logic [0:0]  m_tuser,   // invalid
    output int unsigned fail_count,
    output int unsigned bytes_outstanding
);
    import mse_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       invalid;
    } mov_byte_t;

    mov_byte_t   code_bytes_q[$];
    int unsigned mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected %0h got %0h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic predict_mov(input logic op, input logic [3:0] reg_n,
                               input logic [3:0] rm_n, input logic mem,
                               input logic [1:0] scale, input logic [31:0] disp);
        logic [7:0] rex;
        logic [7:0] sib;
        logic [1:0] mod_f;
        logic [2:0] rm_f;
        logic [7:0] seq[$];
        bit         has_sib;
        bit         short_disp;
        int         disp_len;
        mov_byte_t  b;
        rex        = REX_W | {5'b0, reg_n[3], 2'b0};
        sib        = 8'h00;
        has_sib    = 1'b0;
        disp_len   = 0;
        short_disp = ($signed(disp) >= -128) && ($signed(disp) <= 127);
        if (!mem) begin
            rex[0] = rm_n[3];
            mod_f  = MOD_REG;
            rm_f   = rm_n[2:0];
        end else if (scale != 2'd0) begin
            // stack pointer cannot be an index
            if (rm_n == REG_RSP) begin
                b = '{code: 8'h00, last: 1'b1, invalid: 1'b1};
                code_bytes_q.push_back(b);
                return;
            end
            rex[1]   = rm_n[3];
            mod_f    = MOD_NO_DISP;
            rm_f     = RM_SIB;
            sib      = {scale, rm_n[2:0], SIB_NO_BASE};
            has_sib  = 1'b1;
            disp_len = 4;
        end else begin
            rex[0] = rm_n[3];
            if (rm_n[2:0] == RM_SIB) begin
                rm_f    = RM_SIB;
                sib     = SIB_BASE_ONLY;
                has_sib = 1'b1;
            end else begin
                rm_f = rm_n[2:0];
            end
            // rbp/r13 base needs an explicit zero disp8
            if (disp == 32'd0 && rm_n[2:0] != RM_BP) begin
                mod_f = MOD_NO_DISP;
            end else if (short_disp) begin
                mod_f    = MOD_DISP8;
                disp_len = 1;
            end else begin
                mod_f    = MOD_DISP32;
                disp_len = 4;
            end
        end
        seq.push_back(rex);
        seq.push_back(op == OP_STORE ? OPC_STORE : OPC_LOAD);
        seq.push_back({mod_f, reg_n[2:0], rm_f});
        if (has_sib) seq.push_back(sib);
        for (int i = 0; i < disp_len; i++) seq.push_back(disp[8*i +: 8]);
        foreach (seq[i]) begin
            b = '{code: seq[i], last: (i == seq.size() - 1), invalid: 1'b0};
            code_bytes_q.push_back(b);
        end
    endtask

    always @(posedge aclk) begin
        mov_byte_t want;
        if (!aresetn) begin
            code_bytes_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (code_bytes_q.size() == 0) begin
                    report_mismatch("unexpected byte", 32'd0,
                                    32'({m_tuser, m_tlast, m_tdata}));
                end else begin
                    want = code_bytes_q.pop_front();
                    if (m_tdata !== want.code)
                        report_mismatch("code_byte", 32'(want.code), 32'(m_tdata));
                    if (m_tlast !== want.last)
                        report_mismatch("last_byte", 32'(want.last), 32'(m_tlast));
                    if (m_tuser[0] !== want.invalid)
                        report_mismatch("invalid", 32'(want.invalid), 32'(m_tuser[0]));
                end
            end
            if (s_tvalid && s_tready)
                predict_mov(s_tuser[0], s_tdata[3:0], s_tdata[7:4], s_tuser[1],
                            s_tdata[9:8], s_tdata[41:10]);
        end
        bytes_outstanding <= code_bytes_q.size();
    end

endmodule

// ===== bench/tb_x86_64_modrm_sib_encoder.sv =====
// testbench top for x86_64_modrm_sib_encoder: clock, reset, directed and random
// mov requests under several idle/stall phases, watchdog and final verdict
// depends on mse_pkg, the encoder rtl and mov_encoding_checker
`timescale 1ns / 1ps
module tb_x86_64_modrm_sib_encoder;
    import mse_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // reg_operand, rm_register, scale_code, displacement
    logic [1:0]  s_tuser = '0;   // operation, is_memory
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // code_byte
    logic        m_tlast;
    logic [0:0]  m_tuser;        // invalid

    int unsigned fail_count;
    int unsigned bytes_outstanding;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned quiet_cycles = 0;

    x86_64_modrm_sib_encoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    mov_encoding_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .m_tuser           (m_tuser),
        .fail_count        (fail_count),
        .bytes_outstanding (bytes_outstanding)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // leaves s_tvalid high after the handshake so back-to-back items need no gap
    task automatic send_mov(input logic op, input logic [3:0] reg_n, input logic [3:0] rm_n,
                            input logic mem, input logic [1:0] scale,
                            input logic [31:0] disp);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, disp, scale, rm_n, reg_n};
        s_tuser  <= {mem, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] pick_disp();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'($urandom_range(255)) - 32'd128;
            2: begin
                case ($urandom_range(5))
                    0: return 32'd127;
                    1: return 32'd128;
                    2: return 32'hffff_ff80;
                    3: return 32'hffff_ff7f;
                    4: return 32'h7fff_ffff;
                    default: return 32'h8000_0000;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic run_phase(input int unsigned idle, input int unsigned stall,
                             input int count);
        int         kind;
        logic [3:0] rm_n;
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) begin
            kind = $urandom_range(99);
            rm_n = 4'($urandom_range(15));
            // lean on the base registers with special encodings
            if ($urandom_range(3) == 0) rm_n = {1'($urandom_range(1)), 2'b10,
                                                1'($urandom_range(1))};
            if (kind < 20)
                send_mov(1'($urandom_range(1)), 4'($urandom_range(15)), rm_n, 1'b0,
                         2'($urandom_range(3)), $urandom());
            else if (kind < 65)
                send_mov(1'($urandom_range(1)), 4'($urandom_range(15)), rm_n, 1'b1,
                         2'd0, pick_disp());
            else
                send_mov(1'($urandom_range(1)), 4'($urandom_range(15)), rm_n, 1'b1,
                         2'($urandom_range(1, 3)), pick_disp());
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register direct, scale and displacement ignored
        send_mov(OP_LOAD,  4'd0,  4'd0,  1'b0, 2'd3, 32'hffff_ffff);
        send_mov(OP_STORE, 4'd15, 4'd15, 1'b0, 2'd0, 32'd0);
        send_mov(OP_LOAD,  4'd7,  4'd8,  1'b0, 2'd1, 32'h1234_5678);
        // plain base, every displacement size and its limits
        send_mov(OP_STORE, 4'd1,  4'd0,  1'b1, 2'd0, 32'd0);
        send_mov(OP_LOAD,  4'd9,  4'd3,  1'b1, 2'd0, 32'd127);
        send_mov(OP_STORE, 4'd2,  4'd11, 1'b1, 2'd0, 32'hffff_ff80);
        send_mov(OP_LOAD,  4'd3,  4'd6,  1'b1, 2'd0, 32'd128);
        send_mov(OP_STORE, 4'd10, 4'd14, 1'b1, 2'd0, 32'hffff_ff7f);
        send_mov(OP_LOAD,  4'd4,  4'd1,  1'b1, 2'd0, 32'h7fff_ffff);
        send_mov(OP_STORE, 4'd12, 4'd9,  1'b1, 2'd0, 32'h8000_0000);
        // rsp and r12 base need the sib byte
        send_mov(OP_LOAD,  4'd5,  4'd4,  1'b1, 2'd0, 32'd0);
        send_mov(OP_STORE, 4'd13, 4'd12, 1'b1, 2'd0, 32'd5);
        send_mov(OP_LOAD,  4'd6,  4'd4,  1'b1, 2'd0, 32'd1000);
        // rbp and r13 base with zero offset and with an offset of -1
        send_mov(OP_STORE, 4'd0,  4'd5,  1'b1, 2'd0, 32'd0);
        send_mov(OP_LOAD,  4'd8,  4'd13, 1'b1, 2'd0, 32'd0);
        send_mov(OP_STORE, 4'd11, 4'd5,  1'b1, 2'd0, 32'hffff_ffff);
        // scaled index, r12 allowed as index
        send_mov(OP_LOAD,  4'd14, 4'd1,  1'b1, 2'd1, 32'd16);
        send_mov(OP_STORE, 4'd3,  4'd12, 1'b1, 2'd2, 32'd0);
        send_mov(OP_LOAD,  4'd15, 4'd15, 1'b1, 2'd3, 32'hffff_ffff);
        send_mov(OP_STORE, 4'd7,  4'd5,  1'b1, 2'd3, 32'h8000_0000);
        // stack pointer as index is rejected
        send_mov(OP_LOAD,  4'd2,  4'd4,  1'b1, 2'd1, 32'd8);
        send_mov(OP_STORE, 4'd9,  4'd4,  1'b1, 2'd2, 32'd0);
        send_mov(OP_LOAD,  4'd6,  4'd4,  1'b1, 2'd3, 32'h7fff_ffff);

        run_phase(0, 0, 50);
        run_phase(71, 0, 50);
        // hold off until the encoder has drained completely
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (bytes_outstanding != 0);
        run_phase(0, 71, 50);
        run_phase(12, 12, 50);
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (bytes_outstanding != 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mse_pkg.sv
rtl/core/mse_front.sv
rtl/core/mse_queue.sv
rtl/core/mse_back.sv
rtl/core/x86_64_modrm_sib_encoder.sv
bench/mov_encoding_checker.sv
bench/tb_x86_64_modrm_sib_encoder.sv
